/* rtl/btfd_pkg.sv */
// Shared package of the battery telemetry frame decoder.
// Holds sizing constants, state and opcode types and the subtractor result struct.
// Depends on nothing; every other file of the block but btfd_ram imports it.
package btfd_pkg;

    localparam int NUM_PACKS      = 3;
    localparam int CELLS_PER_PACK = 12;

    localparam int ID_W        = 29;
    localparam int PAYLOAD_W   = 64;
    localparam int IDX_W       = 6;
    localparam int VALUE_W     = 24;
    localparam int MV_W        = 16;
    localparam int TEMP_W      = 9;
    localparam int CHARGE_W    = 23;
    localparam int FLAG_W      = 5;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam int CELL_COUNT  = NUM_PACKS * CELLS_PER_PACK;
    localparam int TEMP_COUNT  = NUM_PACKS * 2;
    localparam int CELL_AW     = $clog2(CELL_COUNT);
    localparam int TEMP_AW     = $clog2(TEMP_COUNT);
    localparam int PACK_W      = (NUM_PACKS > 1) ? $clog2(NUM_PACKS) : 1;
    localparam int MSG_SPAN    = 10;
    localparam int PACK_SPAN   = MSG_SPAN * NUM_PACKS;
    localparam int REM_W       = $clog2(PACK_SPAN);

    localparam int IDX_VOLT    = CELL_COUNT + TEMP_COUNT;
    localparam int IDX_CURR    = IDX_VOLT + 1;
    localparam int IDX_FLAGS   = IDX_VOLT + 2;
    localparam int IDX_WORD    = IDX_VOLT + 3;

    localparam logic [ID_W-1:0]   CONTROLLER_ID   = 29'h274;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET     = 9'd40;
    localparam logic [6:0]        CHARGE_SCALE    = 7'd100;
    localparam logic [FLAG_W-1:0] FLAGS_ALL_SET   = 5'h1F;
    localparam logic [ID_W-1:0]   PACK_BASE_RESET = 29'd300;

    // Register indexes on the configuration port (selected by paddr bit 2).
    localparam logic REG_CHARGER_ID = 1'b0;
    localparam logic REG_PACK_BASE  = 1'b1;

    typedef enum logic [1:0] {
        OP_DECODE = 2'd0,
        OP_CHECK  = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFFSET,
        ST_DIVIDE,
        ST_CELLS,
        ST_CHECK,
        ST_READ,
        ST_FETCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0] diff;
        logic            borrow;
        logic            zero;
    } alu_res_t;

endpackage

/* rtl/btfd_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; used for the cell voltage store.
module btfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 36
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/btfd_alu.sv */
// Shared subtract and compare unit of the decoder sequencer.
// Depends on btfd_pkg for the operand width and the result struct.
module btfd_alu (
    input  logic [btfd_pkg::ID_W-1:0] a,
    input  logic [btfd_pkg::ID_W-1:0] b,
    output btfd_pkg::alu_res_t        res
);
    import btfd_pkg::*;

    logic [ID_W:0] wide_diff;

    assign wide_diff  = {1'b0, a} - {1'b0, b};
    assign res.diff   = wide_diff[ID_W-1:0];
    assign res.borrow = wide_diff[ID_W];
    assign res.zero   = (wide_diff == '0);

endmodule

/* rtl/battery_telemetry_frame_decoder.sv */
// Top level of the battery telemetry frame decoder: sequencer, telemetry store and ports.
// Depends on btfd_pkg, btfd_alu and btfd_ram.
//
// Usage. One operation enters per beat on the s_ channel (valid/ready): a decode of a
// received bus frame, a completeness check, or a read of one stored value. Every operation
// gives exactly one result beat on the m_ channel, carrying the latest check outcome and,
// for a read, the selected value (zero otherwise). The two identifiers the decoder matches
// are set over the APB port; write them only while the block is idle.
//
// Timing. The block works on one operation at a time and drops s_ready from acceptance
// until its result has been loaded into the output register. A bus 0 frame first forms
// the offset from the pack base; a pack frame then takes ten identifiers off per cycle,
// counting the packs until the remainder falls below ten, and a cell frame writes its four
// cells one by one through the single RAM write port. A check inspects one pack per
// cycle. The result register frees the sequencer: a new operation is accepted while a
// result still waits, and only the final load waits for the receiver when it stalls.
//
// Reset. A synchronous active-low reset clears every fresh bit, the stored values and the
// check outcome, and restores the pack base to 300. Cell words behind a clear fresh bit
// read as zero, so the cell RAM needs no clearing pass.
module battery_telemetry_frame_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Operation beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic                              s_bus_index,
    input  logic [btfd_pkg::ID_W-1:0]         s_frame_id,
    input  logic [btfd_pkg::PAYLOAD_W-1:0]    s_payload,
    input  logic [btfd_pkg::IDX_W-1:0]        s_read_index,
    // Result beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_all_ok,
    output logic signed [btfd_pkg::VALUE_W-1:0] m_read_value,
    // Configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [btfd_pkg::APB_AW-1:0]       paddr,
    input  logic [btfd_pkg::APB_DW-1:0]       pwdata,
    output logic [btfd_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);
    import btfd_pkg::*;

    // Sequencer and latched operation
    state_t                 state_reg, state_next;
    logic                   bus_reg, bus_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [PAYLOAD_W-1:0]   payload_reg, payload_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [PACK_W-1:0]      pack_reg, pack_next;
    logic [1:0]             slot_reg, slot_next;
    logic                   ok_reg, ok_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;

    // Configuration registers
    logic [ID_W-1:0]        charger_id_reg, charger_id_next;
    logic [ID_W-1:0]        pack_base_reg, pack_base_next;

    // Telemetry store
    logic [CELL_COUNT-1:0]  cell_fresh_reg, cell_fresh_next;
    logic [TEMP_W-1:0]      temp_reg [TEMP_COUNT];
    logic [TEMP_W-1:0]      temp_next [TEMP_COUNT];
    logic [TEMP_COUNT-1:0]  temp_fresh_reg, temp_fresh_next;
    logic [CHARGE_W-1:0]    voltage_reg, voltage_next;
    logic [CHARGE_W-1:0]    current_reg, current_next;
    logic                   volt_fresh_reg, volt_fresh_next;
    logic                   curr_fresh_reg, curr_fresh_next;
    logic [FLAG_W-1:0]      flags_reg, flags_next;
    logic [MV_W-1:0]        word_reg, word_next;
    logic                   check_reg, check_next;

    // Result register
    logic                   m_valid_reg, m_valid_next;
    logic                   m_all_ok_reg, m_all_ok_next;
    logic signed [VALUE_W-1:0] m_value_reg, m_value_next;

    // Shared subtractor and cell RAM
    logic [ID_W-1:0]        alu_a, alu_b;
    alu_res_t               alu_res;
    logic                   ram_we;
    logic [CELL_AW-1:0]     ram_waddr, ram_raddr;
    logic [MV_W-1:0]        ram_wdata, ram_rdata;

    // Helpers
    logic [3:0]             msg;
    logic [3:0]             cell_in_pack;
    logic [CELL_AW-1:0]     cell_addr;
    logic [TEMP_AW-1:0]     temp_waddr, temp_raddr;
    logic [31:0]            idx32;
    logic                   pack_ok;
    logic                   s_fire, m_free, cfg_write;

    btfd_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    btfd_ram #(
        .WIDTH (MV_W),
        .DEPTH (CELL_COUNT)
    ) u_cell_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign s_fire       = s_valid && s_ready;
    assign m_free       = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_all_ok     = m_all_ok_reg;
    assign m_read_value = m_value_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_PACK_BASE) ? APB_DW'(pack_base_reg)
                                                   : APB_DW'(charger_id_reg);

    // Message number within a pack (remainder minus one) and the cell it addresses.
    assign msg          = 4'(rem_reg) - 4'd1;
    assign cell_in_pack = {msg[1:0], slot_reg};
    assign cell_addr    = CELL_AW'(pack_reg) * CELL_AW'(CELLS_PER_PACK)
                        + CELL_AW'(cell_in_pack);
    assign temp_waddr   = TEMP_AW'({pack_reg, 1'b0});
    assign idx32        = 32'(idx_reg);
    assign temp_raddr   = TEMP_AW'(idx32 - 32'(CELL_COUNT));
    assign ram_raddr    = CELL_AW'(idx_reg);
    assign ram_wdata    = {payload_reg[16*slot_reg +: 8], payload_reg[16*slot_reg + 8 +: 8]};

    // Every fresh bit of the pack under inspection.
    assign pack_ok = (&cell_fresh_reg[pack_reg*CELLS_PER_PACK +: CELLS_PER_PACK])
                  && (&temp_fresh_reg[pack_reg*2 +: 2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            charger_id_reg <= '0;
            pack_base_reg  <= PACK_BASE_RESET;
            cell_fresh_reg <= '0;
            temp_fresh_reg <= '0;
            for (int t = 0; t < TEMP_COUNT; t++) begin
                temp_reg[t] <= '0;
            end
            voltage_reg    <= '0;
            current_reg    <= '0;
            volt_fresh_reg <= 1'b0;
            curr_fresh_reg <= 1'b0;
            flags_reg      <= '0;
            word_reg       <= '0;
            check_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            charger_id_reg <= charger_id_next;
            pack_base_reg  <= pack_base_next;
            cell_fresh_reg <= cell_fresh_next;
            temp_fresh_reg <= temp_fresh_next;
            temp_reg       <= temp_next;
            voltage_reg    <= voltage_next;
            current_reg    <= current_next;
            volt_fresh_reg <= volt_fresh_next;
            curr_fresh_reg <= curr_fresh_next;
            flags_reg      <= flags_next;
            word_reg       <= word_next;
            check_reg      <= check_next;
        end
        // Working registers of the sequencer and the result data need no reset.
        bus_reg      <= bus_next;
        id_reg       <= id_next;
        payload_reg  <= payload_next;
        idx_reg      <= idx_next;
        rem_reg      <= rem_next;
        pack_reg     <= pack_next;
        slot_reg     <= slot_next;
        ok_reg       <= ok_next;
        value_reg    <= value_next;
        m_all_ok_reg <= m_all_ok_next;
        m_value_reg  <= m_value_next;
    end

    always_comb begin
        state_next      = state_reg;
        bus_next        = bus_reg;
        id_next         = id_reg;
        payload_next    = payload_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        pack_next       = pack_reg;
        slot_next       = slot_reg;
        ok_next         = ok_reg;
        value_next      = value_reg;
        charger_id_next = charger_id_reg;
        pack_base_next  = pack_base_reg;
        cell_fresh_next = cell_fresh_reg;
        temp_fresh_next = temp_fresh_reg;
        temp_next       = temp_reg;
        voltage_next    = voltage_reg;
        current_next    = current_reg;
        volt_fresh_next = volt_fresh_reg;
        curr_fresh_next = curr_fresh_reg;
        flags_next      = flags_reg;
        word_next       = word_reg;
        check_next      = check_reg;
        m_valid_next    = m_valid_reg;
        m_all_ok_next   = m_all_ok_reg;
        m_value_next    = m_value_reg;
        alu_a           = id_reg;
        alu_b           = pack_base_reg;
        ram_we          = 1'b0;
        ram_waddr       = cell_addr;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_write) begin
            unique case (paddr[2])
                REG_CHARGER_ID: charger_id_next = pwdata[ID_W-1:0];
                REG_PACK_BASE:  pack_base_next  = pwdata[ID_W-1:0];
                default:        ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    bus_next     = s_bus_index;
                    id_next      = s_frame_id;
                    payload_next = s_payload;
                    idx_next     = s_read_index;
                    value_next   = '0;
                    pack_next    = '0;
                    slot_next    = '0;
                    ok_next      = 1'b1;
                    unique case (opcode_t'(s_opcode))
                        OP_DECODE: state_next = ST_OFFSET;
                        OP_CHECK:  state_next = ST_CHECK;
                        OP_READ:   state_next = ST_READ;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end

            ST_OFFSET: begin
                state_next = ST_DONE;
                if (bus_reg) begin
                    if (id_reg == CONTROLLER_ID) begin
                        word_next = {payload_reg[7:0], payload_reg[15:8]};
                    end
                end else begin
                    if (id_reg == charger_id_reg) begin
                        voltage_next    = CHARGE_W'({payload_reg[7:0], payload_reg[15:8]}
                                                    * CHARGE_SCALE);
                        current_next    = CHARGE_W'({payload_reg[23:16], payload_reg[31:24]}
                                                    * CHARGE_SCALE);
                        volt_fresh_next = 1'b1;
                        curr_fresh_next = 1'b1;
                        flags_next      = payload_reg[39:35];
                    end
                    // Pack frames lie strictly above the base and below base + 10 per pack.
                    if (!alu_res.borrow && !alu_res.zero
                            && alu_res.diff < ID_W'(PACK_SPAN)) begin
                        rem_next   = REM_W'(alu_res.diff);
                        state_next = ST_DIVIDE;
                    end
                end
            end

            ST_DIVIDE: begin
                // Take ten off the offset per cycle; the number taken off is the pack, the rest the message.
                alu_a = ID_W'(rem_reg);
                alu_b = ID_W'(MSG_SPAN);
                if (!alu_res.borrow) begin
                    rem_next  = REM_W'(alu_res.diff);
                    pack_next = pack_reg + 1'b1;
                end else if (rem_reg == '0) begin
                    state_next = ST_DONE;
                end else if (msg < 4'd3) begin
                    state_next = ST_CELLS;
                end else if (msg == 4'd3) begin
                    temp_next[temp_waddr]       = {1'b0, payload_reg[7:0]} - TEMP_OFFSET;
                    temp_next[temp_waddr + 1'b1] = {1'b0, payload_reg[15:8]} - TEMP_OFFSET;
                    temp_fresh_next[temp_waddr]        = 1'b1;
                    temp_fresh_next[temp_waddr + 1'b1] = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_CELLS: begin
                // One cell word per cycle through the RAM write port.
                if (32'(cell_in_pack) < CELLS_PER_PACK) begin
                    ram_we                     = 1'b1;
                    cell_fresh_next[cell_addr] = 1'b1;
                end
                slot_next = slot_reg + 1'b1;
                if (slot_reg == 2'd3) begin
                    state_next = ST_DONE;
                end
            end

            ST_CHECK: begin
                ok_next = ok_reg && pack_ok;
                if (32'(pack_reg) == NUM_PACKS - 1) begin
                    check_next = ok_reg && pack_ok && volt_fresh_reg && curr_fresh_reg
                              && (flags_reg == FLAGS_ALL_SET);
                    state_next = ST_DONE;
                end else begin
                    pack_next = pack_reg + 1'b1;
                end
            end

            ST_READ: begin
                // Cell RAM address is presented; data is there in the next cycle.
                state_next = ST_FETCH;
            end

            ST_FETCH: begin
                if (idx32 < CELL_COUNT) begin
                    value_next = cell_fresh_reg[ram_raddr] ? VALUE_W'(ram_rdata) : '0;
                end else if (idx32 < IDX_VOLT) begin
                    value_next = VALUE_W'($signed(temp_reg[temp_raddr]));
                end else if (idx32 == IDX_VOLT) begin
                    value_next = VALUE_W'(voltage_reg);
                end else if (idx32 == IDX_CURR) begin
                    value_next = VALUE_W'(current_reg);
                end else if (idx32 == IDX_FLAGS) begin
                    value_next = VALUE_W'(flags_reg);
                end else if (idx32 == IDX_WORD) begin
                    value_next = VALUE_W'(word_reg);
                end else begin
                    value_next = '0;
                end
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (m_free) begin
                    m_valid_next  = 1'b1;
                    m_all_ok_next = check_reg;
                    m_value_next  = value_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* rtl/btfd_checker.sv */
// Port-level checker of the battery telemetry frame decoder, with its bind statement.
// Depends on btfd_pkg for the value width and on the top level's port names.
module btfd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_all_ok,
    input logic signed [btfd_pkg::VALUE_W-1:0] m_read_value
);
    import btfd_pkg::*;

    // The block works on one operation at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready stayed high after an operation beat");

    // A result never appears in the cycle straight after its operation was taken.
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result beat appeared one cycle after acceptance");

    // Loading a result returns the sequencer to idle.
    a_idle_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result loaded while the sequencer was still busy");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_all_ok) && $stable(m_read_value)))
        else $error("stalled result beat changed or vanished");

endmodule

bind battery_telemetry_frame_decoder btfd_checker u_btfd_checker (.*);
